// ===== hdl/stun_binding_response_parser_defines.svh =====
// Assertion macros used by the parse module.
`ifndef STUN_BINDING_RESPONSE_PARSER_DEFINES_SVH
`define STUN_BINDING_RESPONSE_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STUNBRP_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stunbrp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define STUNBRP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stunbrp: next-cycle check failed");

`endif

// ===== hdl/stunbrp_pkg.sv =====
`default_nettype none

package stunbrp_pkg;

    localparam logic [16:0] HDR_LEN      = 17'd20;
    localparam logic [16:0] POS_MAX      = 17'h1FFFF;
    localparam logic [15:0] TYPE_SUCCESS = 16'h0101;
    localparam logic [15:0] ATTR_PLAIN   = 16'h0001;
    localparam logic [15:0] ATTR_XOR     = 16'h0020;

    typedef enum logic [1:0] {
        ST_RESOLVED    = 2'd0,
        ST_NOT_SUCCESS = 2'd1,
        ST_IGNORED     = 2'd2,
        ST_TRUNCATED   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  family;
        logic [15:0] mapped_port;
        logic [31:0] mapped_ip;
        logic        from_xor;
    } t_result;

    function automatic logic [7:0] cookie_byte(input logic [1:0] k);
        logic [7:0] v;
        unique case (k)
            2'd0: v = 8'h21;
            2'd1: v = 8'h12;
            2'd2: v = 8'hA4;
            2'd3: v = 8'h42;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/stunbrp_ifs.sv =====
`default_nettype none

interface stunbrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface stunbrp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  family;
    logic [15:0] mapped_port;
    logic [31:0] mapped_ip;
    logic        from_xor;

    modport source (
        output valid, output status, output family, output mapped_port,
        output mapped_ip, output from_xor, input ready
    );
    modport sink (
        input valid, input status, input family, input mapped_port,
        input mapped_ip, input from_xor, output ready
    );
endinterface

`default_nettype wire

// ===== hdl/stunbrp_in_stage.sv =====
`default_nettype none

module stunbrp_in_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    stunbrp_in_if.sink             i_in,
    input  wire                    i_advance,
    output logic                   o_valid,
    output stunbrp_pkg::t_in_item  o_item
);

    logic                  r_valid;
    logic                  n_valid;
    stunbrp_pkg::t_in_item r_item;
    logic                  accept;

    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_item.data_byte <= i_in.data_byte;
            r_item.last_byte <= i_in.last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hdl/stunbrp_parse.sv =====
`default_nettype none

`include "stun_binding_response_parser_defines.svh"

module stunbrp_parse (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_advance,
    input  wire stunbrp_pkg::t_in_item  i_item,
    output stunbrp_pkg::t_result        o_result
);

    logic        r_resolved,    n_resolved;
    logic [16:0] r_pos,         n_pos;
    logic [15:0] r_msg_len,     n_msg_len;
    logic        r_type_failed, n_type_failed;
    logic [15:0] r_attr_type,   n_attr_type;
    logic [15:0] r_attr_len,    n_attr_len;
    logic [15:0] r_attr_start,  n_attr_start;
    logic [7:0]  r_cap_family,  n_cap_family;
    logic [15:0] r_cap_port,    n_cap_port;
    logic [31:0] r_cap_ip,      n_cap_ip;
    logic        r_cap_xor,     n_cap_xor;

    logic [7:0]  b;
    logic [16:0] rel_full;
    logic [15:0] rel;
    logic [15:0] off;
    logic        in_msg;
    logic        attr_hit;
    logic        is_xor;
    logic        known_type;
    logic [16:0] padded;
    logic [15:0] msg_type;
    stunbrp_pkg::t_status status;

    assign b          = i_item.data_byte;
    assign rel_full   = r_pos - stunbrp_pkg::HDR_LEN;
    assign rel        = rel_full[15:0];
    assign in_msg     = (r_pos >= stunbrp_pkg::HDR_LEN) && (rel_full < {1'b0, r_msg_len});
    assign attr_hit   = !r_resolved && !r_type_failed && in_msg && (rel >= r_attr_start);
    assign off        = rel - r_attr_start;
    assign is_xor     = (r_attr_type == stunbrp_pkg::ATTR_XOR);
    assign known_type = (r_attr_type == stunbrp_pkg::ATTR_PLAIN) || is_xor;
    assign msg_type   = r_attr_type | {8'h00, b};

    always_comb begin
        n_resolved    = r_resolved;
        n_pos         = r_pos;
        n_msg_len     = r_msg_len;
        n_type_failed = r_type_failed;
        n_attr_type   = r_attr_type;
        n_attr_len    = r_attr_len;
        n_attr_start  = r_attr_start;
        n_cap_family  = r_cap_family;
        n_cap_port    = r_cap_port;
        n_cap_ip      = r_cap_ip;
        n_cap_xor     = r_cap_xor;
        padded        = 17'd0;
        status        = stunbrp_pkg::ST_RESOLVED;

        if (!r_resolved) begin
            if (r_pos == 17'd0) begin
                n_attr_type = {b, 8'h00};
            end else if (r_pos == 17'd1) begin
                n_type_failed = (msg_type != stunbrp_pkg::TYPE_SUCCESS);
                n_attr_type   = 16'h0000;
            end else if (r_pos == 17'd2) begin
                n_msg_len = {b, 8'h00};
            end else if (r_pos == 17'd3) begin
                n_msg_len = r_msg_len | {8'h00, b};
            end else if (attr_hit) begin
                if (off == 16'd0) begin
                    n_attr_type = {b, 8'h00};
                end else if (off == 16'd1) begin
                    n_attr_type = r_attr_type | {8'h00, b};
                end else if (off == 16'd2) begin
                    n_attr_len = {b, 8'h00};
                end else if (off == 16'd3) begin
                    n_attr_len = r_attr_len | {8'h00, b};
                end else if (((off - 16'd4) < r_attr_len) && known_type) begin
                    if ((off >= 16'd5) && (off <= 16'd11)) begin
                        n_cap_xor = is_xor;
                    end
                    unique case (off)
                        16'd5: n_cap_family = b;
                        16'd6: n_cap_port[15:8] = b ^ (is_xor ? stunbrp_pkg::cookie_byte(2'd0) : 8'h00);
                        16'd7: n_cap_port[7:0]  = b ^ (is_xor ? stunbrp_pkg::cookie_byte(2'd1) : 8'h00);
                        16'd8: n_cap_ip[31:24]  = b ^ (is_xor ? stunbrp_pkg::cookie_byte(2'd0) : 8'h00);
                        16'd9: n_cap_ip[23:16]  = b ^ (is_xor ? stunbrp_pkg::cookie_byte(2'd1) : 8'h00);
                        16'd10: n_cap_ip[15:8]  = b ^ (is_xor ? stunbrp_pkg::cookie_byte(2'd2) : 8'h00);
                        16'd11: n_cap_ip[7:0]   = b ^ (is_xor ? stunbrp_pkg::cookie_byte(2'd3) : 8'h00);
                        default: ;
                    endcase
                end
                if (off >= 16'd3) begin
                    padded = ({1'b0, n_attr_len} + 17'd3) & ~17'd3;
                    if ({2'b00, off} == ({1'b0, padded} + 18'd3)) begin
                        n_attr_start = rel + 16'd1;
                    end
                end
            end
        end

        priority if (r_resolved) begin
            status = stunbrp_pkg::ST_IGNORED;
        end else if (n_type_failed) begin
            status = stunbrp_pkg::ST_NOT_SUCCESS;
        end else if (({1'b0, r_pos} + 18'd1) <
                     ({1'b0, stunbrp_pkg::HDR_LEN} + {2'b00, n_msg_len})) begin
            status = stunbrp_pkg::ST_TRUNCATED;
        end else begin
            status = stunbrp_pkg::ST_RESOLVED;
        end

        if (i_item.last_byte) begin
            if (status == stunbrp_pkg::ST_RESOLVED) begin
                n_resolved = 1'b1;
            end
            n_pos         = 17'd0;
            n_msg_len     = 16'd0;
            n_type_failed = 1'b0;
            n_attr_type   = 16'd0;
            n_attr_len    = 16'd0;
            n_attr_start  = 16'd0;
        end else begin
            n_pos = (r_pos < stunbrp_pkg::POS_MAX) ? r_pos + 17'd1 : stunbrp_pkg::POS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolved    <= 1'b0;
            r_pos         <= 17'd0;
            r_msg_len     <= 16'd0;
            r_type_failed <= 1'b0;
            r_attr_type   <= 16'd0;
            r_attr_len    <= 16'd0;
            r_attr_start  <= 16'd0;
            r_cap_family  <= 8'd0;
            r_cap_port    <= 16'd0;
            r_cap_ip      <= 32'd0;
            r_cap_xor     <= 1'b0;
        end else if (i_advance) begin
            r_resolved    <= n_resolved;
            r_pos         <= n_pos;
            r_msg_len     <= n_msg_len;
            r_type_failed <= n_type_failed;
            r_attr_type   <= n_attr_type;
            r_attr_len    <= n_attr_len;
            r_attr_start  <= n_attr_start;
            r_cap_family  <= n_cap_family;
            r_cap_port    <= n_cap_port;
            r_cap_ip      <= n_cap_ip;
            r_cap_xor     <= n_cap_xor;
        end
    end

    always_comb begin
        o_result.status      = status;
        o_result.family      = n_cap_family;
        o_result.mapped_port = n_cap_port;
        o_result.mapped_ip   = n_cap_ip;
        o_result.from_xor    = n_cap_xor;
    end

    `STUNBRP_ASSERT_NEXT(a_resolved_sticky, i_clk, i_rst_n, r_resolved, r_resolved)
    `STUNBRP_ASSERT_NEXT(a_last_clears_pos, i_clk, i_rst_n,
        i_advance && i_item.last_byte, (r_pos == 17'd0) && !r_type_failed)
    `STUNBRP_ASSERT_SAME(a_fail_after_type, i_clk, i_rst_n, r_type_failed, r_pos >= 17'd2)
    `STUNBRP_ASSERT_NEXT(a_resolve_sets_flag, i_clk, i_rst_n,
        i_advance && i_item.last_byte && (status == stunbrp_pkg::ST_RESOLVED), r_resolved)

endmodule

`default_nettype wire

// ===== hdl/stunbrp_out_stage.sv =====
`default_nettype none

module stunbrp_out_stage (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_load,
    input  wire stunbrp_pkg::t_result  i_result,
    output logic                       o_free,
    stunbrp_out_if.source              o_out
);

    logic                 r_valid;
    logic                 n_valid;
    stunbrp_pkg::t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_result.status;
    assign o_out.family      = r_result.family;
    assign o_out.mapped_port = r_result.mapped_port;
    assign o_out.mapped_ip   = r_result.mapped_ip;
    assign o_out.from_xor    = r_result.from_xor;

endmodule

`default_nettype wire

// ===== hdl/stun_binding_response_parser.sv =====
// Channel | Direction | Payload                                              | Transaction
// i_in    | in        | data_byte[7:0], last_byte                             | valid && ready
// o_out   | out       | status[1:0], family[7:0], mapped_port[15:0],
//         |           | mapped_ip[31:0], from_xor                             | valid && ready
//
// One byte is taken per cycle while no last byte waits on a stalled result; the result for a
// last byte becomes valid when the parse step loads it from the input register into the result register.
// The per-byte parse step between those registers sets the rate of one byte per cycle when not stalled.
// Reset is synchronous and active low and clears all parser state and the valid flags of both stages.
// A stalled result holds only bytes marked last; other bytes keep flowing behind it.
`default_nettype none

module stun_binding_response_parser (
    input  wire            i_clk,
    input  wire            i_rst_n,
    stunbrp_in_if.sink     i_in,
    stunbrp_out_if.source  o_out
);

    logic                  in_valid;
    stunbrp_pkg::t_in_item in_item;
    logic                  out_free;
    logic                  advance;
    stunbrp_pkg::t_result  result;

    assign advance = in_valid && (!in_item.last_byte || out_free);

    stunbrp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    stunbrp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (in_item),
        .o_result  (result)
    );

    stunbrp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && in_item.last_byte),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/stunbrp_status_checker.sv =====
module stunbrp_status_checker
    import stunbrp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    stunbrp_in_if        i_byte_ch,
    stunbrp_out_if       i_result_ch,
    output int unsigned  o_error_count,
    output int unsigned  o_pending,
    output int unsigned  o_result_count
);

    localparam logic [31:0] COOKIE = 32'h2112A442;

    logic        resolved;
    logic [16:0] byte_pos;
    logic [15:0] msg_len;
    logic        bad_type;
    logic [15:0] attr_type;
    logic [15:0] attr_len;
    logic [16:0] attr_start;
    logic [7:0]  cap_family;
    logic [15:0] cap_port;
    logic [31:0] cap_ip;
    logic        cap_xor;

    t_result     expected_statuses[$];
    int unsigned error_total   = 0;
    int unsigned pending_total = 0;
    int unsigned result_total  = 0;

    assign o_error_count  = error_total;
    assign o_pending      = pending_total;
    assign o_result_count = result_total;

    task automatic clear_message();
        byte_pos   = '0;
        msg_len    = '0;
        bad_type   = 1'b0;
        attr_type  = '0;
        attr_len   = '0;
        attr_start = '0;
    endtask

    task automatic capture_value(input int unsigned off, input logic [7:0] b);
        logic [7:0] v;
        logic       use_xor;
        int         k;
        use_xor = (attr_type == ATTR_XOR);
        if (off >= 5 && off <= 11) begin
            v = b;
            if (off == 5) begin
                cap_family = v;
            end else begin
                k = (off <= 7) ? off - 6 : off - 8;
                if (use_xor) begin
                    v = v ^ COOKIE[31 - 8 * k -: 8];
                end
                if (off <= 7) begin
                    cap_port[15 - 8 * k -: 8] = v;
                end else begin
                    cap_ip[31 - 8 * k -: 8] = v;
                end
            end
            cap_xor = use_xor;
        end
    endtask

    task automatic walk_attribute(input int unsigned rel, input logic [7:0] b);
        int unsigned off;
        int unsigned padded;
        int unsigned next_start;
        if (rel >= attr_start) begin
            off = rel - attr_start;
            if (off == 0) begin
                attr_type = {b, 8'h00};
            end else if (off == 1) begin
                attr_type = attr_type | {8'h00, b};
            end else if (off == 2) begin
                attr_len = {b, 8'h00};
            end else if (off == 3) begin
                attr_len = attr_len | {8'h00, b};
            end else if (off - 4 < attr_len &&
                         (attr_type == ATTR_PLAIN || attr_type == ATTR_XOR)) begin
                capture_value(off, b);
            end
            if (off >= 3) begin
                padded = (32'(attr_len) + 32'd3) & 32'hFFFF_FFFC;
                if (off == 3 + padded) begin
                    next_start = rel + 1;
                    if (next_start > msg_len) begin
                        next_start = msg_len;
                    end
                    attr_start = 17'(next_start);
                end
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic is_last,
                              output bit made, output t_result status_out);
        int unsigned p;
        p = byte_pos;
        if (!resolved) begin
            if (p == 0) begin
                attr_type = {b, 8'h00};
            end else if (p == 1) begin
                attr_type = attr_type | {8'h00, b};
                bad_type  = (attr_type != TYPE_SUCCESS);
                attr_type = '0;
            end else if (p == 2) begin
                msg_len = {b, 8'h00};
            end else if (p == 3) begin
                msg_len = msg_len | {8'h00, b};
            end else if (p >= HDR_LEN && !bad_type && p - HDR_LEN < msg_len) begin
                walk_attribute(p - HDR_LEN, b);
            end
        end
        made = is_last;
        status_out = '0;
        if (!is_last) begin
            byte_pos = (byte_pos < POS_MAX) ? byte_pos + 17'd1 : POS_MAX;
        end else begin
            if (resolved) begin
                status_out.status = ST_IGNORED;
            end else if (bad_type) begin
                status_out.status = ST_NOT_SUCCESS;
            end else if (p + 1 < 32'(HDR_LEN) + 32'(msg_len)) begin
                status_out.status = ST_TRUNCATED;
            end else begin
                status_out.status = ST_RESOLVED;
                resolved = 1'b1;
            end
            status_out.family      = cap_family;
            status_out.mapped_port = cap_port;
            status_out.mapped_ip   = cap_ip;
            status_out.from_xor    = cap_xor;
            clear_message();
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        error_total++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result predicted;
        bit      made;
        if (!i_rst_n) begin
            resolved   = 1'b0;
            cap_family = '0;
            cap_port   = '0;
            cap_ip     = '0;
            cap_xor    = 1'b0;
            clear_message();
            expected_statuses.delete();
        end else begin
            if (i_result_ch.valid && i_result_ch.ready) begin
                result_total++;
                if (expected_statuses.size() == 0) begin
                    $error("Status result arrived while none was expected.");
                    error_total++;
                end else begin
                    want = expected_statuses.pop_front();
                    if (i_result_ch.status !== want.status) begin
                        flag_mismatch("status", 32'(want.status), 32'(i_result_ch.status));
                    end
                    if (i_result_ch.family !== want.family) begin
                        flag_mismatch("family", 32'(want.family), 32'(i_result_ch.family));
                    end
                    if (i_result_ch.mapped_port !== want.mapped_port) begin
                        flag_mismatch("mapped_port", 32'(want.mapped_port),
                                      32'(i_result_ch.mapped_port));
                    end
                    if (i_result_ch.mapped_ip !== want.mapped_ip) begin
                        flag_mismatch("mapped_ip", want.mapped_ip, i_result_ch.mapped_ip);
                    end
                    if (i_result_ch.from_xor !== want.from_xor) begin
                        flag_mismatch("from_xor", 32'(want.from_xor),
                                      32'(i_result_ch.from_xor));
                    end
                end
            end
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                parse_byte(i_byte_ch.data_byte, i_byte_ch.last_byte, made, predicted);
                if (made) begin
                    expected_statuses.push_back(predicted);
                end
            end
        end
        pending_total = expected_statuses.size();
    end

endmodule

// ===== tb/stun_binding_response_parser_tb.sv =====
module stun_binding_response_parser_tb;
    import stunbrp_pkg::*;

    localparam int unsigned RANDOM_BYTES       = 1200;
    localparam int unsigned HOLD_CYCLES        = 300;
    localparam int unsigned PRESSURE_DATAGRAMS = 40;
    localparam int unsigned LONG_DATAGRAM      = 60;
    localparam int unsigned WATCHDOG_LIMIT     = 2000;
    localparam int unsigned DRAIN_CYCLES       = 10;

    logic clk;
    logic rst_n;

    stunbrp_in_if  byte_ch ();
    stunbrp_out_if result_ch ();

    int unsigned error_count;
    int unsigned pending_count;
    int unsigned result_count;

    logic [7:0]  datagram[$];
    int unsigned bytes_sent     = 0;
    int unsigned datagrams_sent = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned rx_hold_seq    = 0;
    bit          tx_idle_on     = 1'b0;
    bit          rx_idle_on     = 1'b0;
    bit          pressure_done  = 1'b0;

    stun_binding_response_parser u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    stunbrp_status_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_byte_ch      (byte_ch),
        .i_result_ch    (result_ch),
        .o_error_count  (error_count),
        .o_pending      (pending_count),
        .o_result_count (result_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned hold_seen;
        hold_seen = 0;
        result_ch.ready = 1'b1;
        forever begin
            @(negedge clk);
            if (rx_hold_seq != hold_seen) begin
                hold_seen = rx_hold_seq;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic is_last);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        byte_ch.last_byte <= is_last;
        do begin
            @(posedge clk);
        end while (!byte_ch.ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_datagram();
        foreach (datagram[i]) begin
            push_byte(datagram[i], i == datagram.size() - 1);
        end
        datagrams_sent++;
    endtask

    task automatic start_datagram(input logic [15:0] msg_type);
        datagram.delete();
        datagram.push_back(msg_type[15:8]);
        datagram.push_back(msg_type[7:0]);
        repeat (18) datagram.push_back(8'($urandom));
    endtask

    task automatic add_attribute(input logic [15:0] a_type, input logic [15:0] a_len,
                                 input int unsigned value_bytes);
        datagram.push_back(a_type[15:8]);
        datagram.push_back(a_type[7:0]);
        datagram.push_back(a_len[15:8]);
        datagram.push_back(a_len[7:0]);
        repeat (value_bytes) datagram.push_back(8'($urandom));
    endtask

    task automatic make_noise(input int unsigned max_len);
        datagram.delete();
        repeat ($urandom_range(1, max_len)) datagram.push_back(8'($urandom));
    endtask

    // A success response that always ends short of its stated message length,
    // so that it is parsed in full but never resolves the parser.
    task automatic make_response();
        int unsigned n_attr;
        int unsigned pick;
        int unsigned value_bytes;
        int unsigned body;
        int unsigned msg_bytes;
        int unsigned keep;
        logic [15:0] a_type;
        logic [15:0] a_len;
        bit          open_ended;
        start_datagram(TYPE_SUCCESS);
        n_attr = $urandom_range(1, 3);
        open_ended = 1'b0;
        for (int i = 0; i < n_attr && !open_ended; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                a_type = ATTR_XOR;
            end else if (pick < 7) begin
                a_type = ATTR_PLAIN;
            end else if (pick == 7) begin
                a_type = ATTR_XOR ^ (16'h0001 << $urandom_range(0, 15));
            end else begin
                a_type = 16'($urandom);
            end
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                a_len = 16'd8;
            end else if (pick < 16) begin
                a_len = 16'($urandom_range(0, 7));
            end else if (pick < 19) begin
                a_len = 16'($urandom_range(9, 20));
            end else begin
                a_len = 16'($urandom);
                open_ended = 1'b1;
            end
            if (open_ended) begin
                value_bytes = $urandom_range(0, 12);
            end else begin
                value_bytes = (32'(a_len) + 32'd3) & 32'hFFFF_FFFC;
            end
            add_attribute(a_type, a_len, value_bytes);
        end
        body = datagram.size() - 20;
        if ($urandom_range(0, 4) != 0) begin
            msg_bytes = body + $urandom_range(1, 8);
        end else begin
            msg_bytes = $urandom_range(body + 1, 65535);
        end
        datagram[2] = 8'(msg_bytes >> 8);
        datagram[3] = 8'(msg_bytes);
        if ($urandom_range(0, 9) < 3) begin
            keep = $urandom_range(1, datagram.size());
            while (datagram.size() > keep) void'(datagram.pop_back());
        end
    endtask

    task automatic make_random_datagram();
        int unsigned pick;
        logic [15:0] msg_type;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            make_response();
        end else if (pick < 8) begin
            if ($urandom_range(0, 1) == 0) begin
                msg_type = 16'($urandom);
            end else begin
                msg_type = TYPE_SUCCESS ^ (16'h0001 << $urandom_range(0, 15));
            end
            if (msg_type == TYPE_SUCCESS) begin
                msg_type = ~msg_type;
            end
            start_datagram(msg_type);
            repeat ($urandom_range(0, 24)) datagram.push_back(8'($urandom));
            pick = $urandom_range(2, datagram.size());
            while (datagram.size() > pick) void'(datagram.pop_back());
        end else begin
            make_noise(19);
        end
    endtask

    initial begin : stimulus
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_on = 1'b1;
        datagram = '{8'h00};
        send_datagram();
        datagram = '{8'hFF, 8'hFF, 8'h00};
        send_datagram();
        datagram = '{8'h01, 8'h01};
        send_datagram();
        datagram = '{8'h01, 8'h01, 8'hFF, 8'hFF, 8'h80, 8'h7F};
        send_datagram();

        while (bytes_sent < RANDOM_BYTES) begin
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on <= ($urandom_range(0, 2) != 0);
            if (!pressure_done && bytes_sent > RANDOM_BYTES / 2) begin
                pressure_done = 1'b1;
                rx_hold_seq <= rx_hold_seq + 1;
                repeat (PRESSURE_DATAGRAMS) begin
                    make_noise(2);
                    send_datagram();
                end
            end else begin
                make_random_datagram();
                send_datagram();
            end
        end

        // The one datagram that resolves: an XOR address, then a plain address cut
        // off by the message end, then trailing bytes past the message.
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        start_datagram(TYPE_SUCCESS);
        add_attribute(ATTR_XOR, 16'd8, 8);
        add_attribute(ATTR_PLAIN, 16'd8, 8);
        datagram[2] = 8'h00;
        datagram[3] = 8'd20;
        while (datagram.size() < LONG_DATAGRAM) datagram.push_back(8'($urandom));
        send_datagram();
        repeat (4) begin
            make_random_datagram();
            send_datagram();
        end
        byte_ch.valid <= 1'b0;

        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d bytes in %0d datagrams, with a %0d-byte datagram that resolves.",
                 bytes_sent, datagrams_sent, LONG_DATAGRAM);
        $display("Checked %0d status results, %0d of them under a long output stall.",
                 result_count, PRESSURE_DATAGRAMS);
        if (error_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/stunbrp_pkg.sv
hdl/stunbrp_ifs.sv
hdl/stunbrp_in_stage.sv
hdl/stunbrp_parse.sv
hdl/stunbrp_out_stage.sv
hdl/stun_binding_response_parser.sv
tb/stunbrp_status_checker.sv
tb/stun_binding_response_parser_tb.sv
